### hw/rtl/tmac_pkg.sv
// Shared types, constants and helper functions for the multipole acceptance test block.
package tmac_pkg;

  // Default sizing of the interaction list and of the sink split test.
  localparam int LIST_DEPTH_DEF   = 4096;
  localparam int SPLIT_FACTOR_DEF = 4;

  // Byte-aligned word widths on the stream channels.
  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 64;

  // Outcome of the acceptance test.
  typedef enum logic [1:0] {
    DEC_ACCEPT     = 2'd0,
    DEC_SPLIT_SRC  = 2'd1,
    DEC_SPLIT_SINK = 2'd2
  } dec_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SINK_X       = 3'd0,
    REG_SINK_Y       = 3'd1,
    REG_SINK_Z       = 3'd2,
    REG_SINK_EXTENT  = 3'd3,
    REG_SINK_IS_BODY = 3'd4,
    REG_MAC_MODE     = 3'd5,
    REG_START_COUNT  = 3'd6,
    REG_START_INTER  = 3'd7
  } reg_idx_t;

  // Reset value of the acceptance mode register (sink-extent mode).
  localparam logic [1:0] MAC_MODE_RESET = 2'd1;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [23:0] sink_x;
    logic signed [23:0] sink_y;
    logic signed [23:0] sink_z;
    logic [23:0]        sink_extent;
    logic               sink_is_body;
    logic [1:0]         mac_mode;
    logic [12:0]        start_count;
    logic [31:0]        start_interactions;
  } cfg_t;

  // Register file contents after reset.
  localparam cfg_t CFG_RESET = '{
    sink_x:             24'sd0,
    sink_y:             24'sd0,
    sink_z:             24'sd0,
    sink_extent:        24'd0,
    sink_is_body:       1'b0,
    mac_mode:           MAC_MODE_RESET,
    start_count:        13'd0,
    start_interactions: 32'd0
  };

  // One tree source as taken from the input channel.
  typedef struct packed {
    logic               is_cell;
    logic [31:0]        mass;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [23:0]        rcrit;
    logic [23:0]        extent;
    logic [23:0]        daughters;
    logic               batch_first;
  } src_t;

  // Source after the squaring stage.
  typedef struct packed {
    logic               is_cell;
    logic [31:0]        mass;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [23:0]        daughters;
    logic               batch_first;
    logic [47:0]        dx2;
    logic [47:0]        dy2;
    logic [47:0]        dz2;
    logic [49:0]        rb2;
    logic [47:0]        rc2;
    logic               sink_split;
  } geom_t;

  // Result word fields, last field in the lowest bits.
  typedef struct packed {
    logic        split_body_error;
    logic        list_full;
    logic [31:0] interaction_total;
    logic [12:0] list_count_now;
    logic [11:0] list_slot;
  } res_t;

  // Magnitude of the difference of two signed Q12.12 coordinates.
  function automatic logic [23:0] abs_diff(logic signed [23:0] a, logic signed [23:0] b);
    logic [24:0] d;
    logic [24:0] n;
    d = {a[23], a} - {b[23], b};
    n = -d;
    return d[24] ? n[23:0] : d[23:0];
  endfunction

endpackage

### hw/rtl/tmac_list_mem.sv
// Interaction list storage: mass and position memories with one write port.
module tmac_list_mem
  import tmac_pkg::*;
#(
  parameter int DEPTH  = LIST_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_mass,
  input  logic [71:0]       wr_pos
);

  logic [31:0] mass_mem [DEPTH];
  logic [71:0] pos_mem  [DEPTH];

  // Append an accepted source at the slot chosen by the list counter.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mass_mem[wr_addr] <= wr_mass;
      pos_mem[wr_addr]  <= wr_pos;
    end
  end

endmodule

### hw/rtl/tmac_geom.sv
// Squaring stage: coordinate distances, radius sums and their squares.
module tmac_geom
  import tmac_pkg::*;
#(
  parameter int SPLIT_FACTOR = SPLIT_FACTOR_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  src_valid,
  output logic  src_ready,
  input  src_t  src,
  output logic  geom_valid,
  input  logic  geom_ready,
  output geom_t geom
);

  localparam int SF_W  = $clog2(SPLIT_FACTOR + 1);
  localparam int SPL_W = 24 + SF_W;

  logic        geom_valid_r, geom_valid_nxt;
  geom_t       geom_r;
  logic        adv;
  logic [23:0] dx, dy, dz;
  logic [23:0] r_sel;
  logic [24:0] rb;
  logic [SPL_W-1:0] sink_scaled;

  assign src_ready  = !geom_valid_r || geom_ready;
  assign adv        = src_valid && src_ready;
  assign geom_valid = geom_valid_r;
  assign geom       = geom_r;

  // Distances and combined radius for the acceptance test.
  always_comb begin
    dx    = abs_diff(src.x, cfg.sink_x);
    dy    = abs_diff(src.y, cfg.sink_y);
    dz    = abs_diff(src.z, cfg.sink_z);
    r_sel = (cfg.mac_mode[1] && (src.extent > src.rcrit)) ? src.extent : src.rcrit;
    rb    = {1'b0, r_sel} + {1'b0, cfg.sink_extent};
    sink_scaled = SPL_W'(SPLIT_FACTOR) * SPL_W'(cfg.sink_extent);
    geom_valid_nxt = geom_valid_r;
    if (adv) begin
      geom_valid_nxt = 1'b1;
    end else if (geom_ready) begin
      geom_valid_nxt = 1'b0;
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_valid_r <= 1'b0;
    end else begin
      geom_valid_r <= geom_valid_nxt;
    end
  end

  // Squares are registered before the distance sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      geom_r.is_cell     <= src.is_cell;
      geom_r.mass        <= src.mass;
      geom_r.x           <= src.x;
      geom_r.y           <= src.y;
      geom_r.z           <= src.z;
      geom_r.daughters   <= src.daughters;
      geom_r.batch_first <= src.batch_first;
      geom_r.dx2         <= dx * dx;
      geom_r.dy2         <= dy * dy;
      geom_r.dz2         <= dz * dz;
      geom_r.rb2         <= rb * rb;
      geom_r.rc2         <= src.rcrit * src.rcrit;
      geom_r.sink_split  <= sink_scaled > SPL_W'(rb);
    end
  end

endmodule

### hw/rtl/tmac_decide.sv
// Decision stage: distance compare, list counter update and the result register.
module tmac_decide
  import tmac_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int ADDR_W     = $clog2(LIST_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              geom_valid,
  output logic              geom_ready,
  input  geom_t             geom,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [31:0]       wr_mass,
  output logic [71:0]       wr_pos,
  output logic              res_valid,
  input  logic              res_ready,
  output dec_t              res_dec,
  output res_t              res
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;

  logic             res_valid_r, res_valid_nxt;
  dec_t             res_dec_r;
  res_t             res_r, res_nxt;
  logic [CNT_W-1:0] list_count_r, list_count_nxt;
  logic [31:0]      inter_r, inter_nxt;
  logic             adv;
  logic [49:0]      dr2;
  dec_t             dec;
  logic [CNT_W-1:0] start_clamped, cnt_base;
  logic [31:0]      inter_base;
  logic [32:0]      inter_sum;
  logic             full;
  logic             append;

  assign geom_ready = !res_valid_r || res_ready;
  assign adv        = geom_valid && geom_ready;
  assign res_valid  = res_valid_r;
  assign res_dec    = res_dec_r;
  assign res        = res_r;

  // Acceptance decision, counter update and list append.
  always_comb begin
    dr2 = {2'b0, geom.dx2} + {2'b0, geom.dy2} + {2'b0, geom.dz2};
    if (cfg.mac_mode == 2'd0 && !cfg.sink_is_body) begin
      dec = DEC_SPLIT_SINK;
    end else if (!geom.is_cell) begin
      dec = DEC_ACCEPT;
    end else if (cfg.mac_mode == 2'd0) begin
      dec = (dr2 < {2'b0, geom.rc2}) ? DEC_SPLIT_SRC : DEC_ACCEPT;
    end else if (dr2 > geom.rb2) begin
      dec = DEC_ACCEPT;
    end else begin
      dec = geom.sink_split ? DEC_SPLIT_SINK : DEC_SPLIT_SRC;
    end

    if (CMP_W'(cfg.start_count) > CMP_W'(LIST_DEPTH)) begin
      start_clamped = CNT_W'(LIST_DEPTH);
    end else begin
      start_clamped = CNT_W'(cfg.start_count);
    end
    cnt_base   = geom.batch_first ? start_clamped : list_count_r;
    inter_base = geom.batch_first ? cfg.start_interactions : inter_r;
    inter_sum  = {1'b0, inter_base} +
                 (geom.is_cell ? {9'b0, geom.daughters} : 33'd1);

    full   = (dec == DEC_ACCEPT) && (cnt_base >= CNT_W'(LIST_DEPTH));
    append = (dec == DEC_ACCEPT) && !full;

    list_count_nxt = cnt_base;
    inter_nxt      = inter_base;
    res_nxt.list_slot = '0;
    if (append) begin
      list_count_nxt    = cnt_base + 1'b1;
      inter_nxt         = inter_sum[32] ? 32'hFFFF_FFFF : inter_sum[31:0];
      res_nxt.list_slot = 12'(cnt_base);
    end
    res_nxt.list_count_now    = 13'(list_count_nxt);
    res_nxt.interaction_total = inter_nxt;
    res_nxt.list_full         = full;
    res_nxt.split_body_error  = (dec == DEC_SPLIT_SINK) && cfg.sink_is_body;

    res_valid_nxt = res_valid_r;
    if (adv) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  assign wr_en   = adv && append;
  assign wr_addr = cnt_base[ADDR_W-1:0];
  assign wr_mass = geom.mass;
  assign wr_pos  = {geom.z, geom.y, geom.x};

  // Control state: counters and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      list_count_r <= '0;
      inter_r      <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (adv) begin
        list_count_r <= list_count_nxt;
        inter_r      <= inter_nxt;
      end
    end
  end

  // Result word held until the consumer takes it.
  always_ff @(posedge clk) begin
    if (adv) begin
      res_dec_r <= dec;
      res_r     <= res_nxt;
    end
  end

endmodule

### hw/rtl/tree_multipole_acceptance_test_top.sv
// Each source word passes the input register, the squaring register and the result register
// in that order before its result word is valid on the output.
// Throughput: one source per cycle unless stalled; the squaring stage and the list write port
// each take one item every cycle, and each stage moves on when the one after it is free.
// Reset (synchronous, rst_n low) clears the stage valid flags, the list and interaction
// counters and the configuration registers (mode to sink-extent); list memory stays undefined.
module tree_multipole_acceptance_test_top
  import tmac_pkg::*;
#(
  parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
  parameter int SPLIT_FACTOR = SPLIT_FACTOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [31:0]           cfg_wdata,
  // Source words.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mass[31:0], x[55:32], y[79:56], z[103:80], rcrit[127:104],
  // extent[151:128], daughters[175:152], batch_first[176], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // source_is_cell[0]
  input  logic [0:0]            in_tuser,
  // Result words.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // list_slot[11:0], list_count_now[24:12], interaction_total[56:25],
  // list_full[57], split_body_error[58], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // decision[1:0]
  output logic [1:0]            out_tuser
);

  localparam int ADDR_W = $clog2(LIST_DEPTH);

  cfg_t              cfg_r;
  logic              s1_valid_r, s1_valid_nxt;
  src_t              s1_r, src_in;
  logic              s1_ready;
  logic              geom_valid, geom_ready;
  geom_t             geom;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_mass;
  logic [71:0]       wr_pos;
  dec_t              res_dec;
  res_t              res;
  logic              in_acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SINK_X:       cfg_r.sink_x             <= cfg_wdata[23:0];
        REG_SINK_Y:       cfg_r.sink_y             <= cfg_wdata[23:0];
        REG_SINK_Z:       cfg_r.sink_z             <= cfg_wdata[23:0];
        REG_SINK_EXTENT:  cfg_r.sink_extent        <= cfg_wdata[23:0];
        REG_SINK_IS_BODY: cfg_r.sink_is_body       <= cfg_wdata[0];
        REG_MAC_MODE:     cfg_r.mac_mode           <= cfg_wdata[1:0];
        REG_START_COUNT:  cfg_r.start_count        <= cfg_wdata[12:0];
        REG_START_INTER:  cfg_r.start_interactions <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the incoming word.
  always_comb begin
    src_in.is_cell     = in_tuser[0];
    src_in.mass        = in_tdata[31:0];
    src_in.x           = in_tdata[55:32];
    src_in.y           = in_tdata[79:56];
    src_in.z           = in_tdata[103:80];
    src_in.rcrit       = in_tdata[127:104];
    src_in.extent      = in_tdata[151:128];
    src_in.daughters   = in_tdata[175:152];
    src_in.batch_first = in_tdata[176];
  end

  // Input register stage.
  assign in_tready = !s1_valid_r || s1_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= src_in;
    end
  end

  tmac_geom #(
    .SPLIT_FACTOR(SPLIT_FACTOR)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .src_valid (s1_valid_r),
    .src_ready (s1_ready),
    .src       (s1_r),
    .geom_valid(geom_valid),
    .geom_ready(geom_ready),
    .geom      (geom)
  );

  tmac_decide #(
    .LIST_DEPTH(LIST_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .geom_valid(geom_valid),
    .geom_ready(geom_ready),
    .geom      (geom),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_mass   (wr_mass),
    .wr_pos    (wr_pos),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_dec   (res_dec),
    .res       (res)
  );

  tmac_list_mem #(
    .DEPTH (LIST_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_list_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_mass(wr_mass),
    .wr_pos (wr_pos)
  );

  // Pack the result word.
  assign out_tdata = {5'b0, res};
  assign out_tuser = res_dec;

endmodule

### hw/rtl/tmac_checker.sv
// Port-level checks for the multipole acceptance test block and their binding.
module tmac_checker
  import tmac_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // No result word is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // A full list is only reported for an accepted source.
  a_full_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[57] |-> out_tuser == DEC_ACCEPT)
    else $error("list full flagged without acceptance");

  // A body-sink split error goes with a split sink decision.
  a_body_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[58] |-> out_tuser == DEC_SPLIT_SINK)
    else $error("split body error without split sink");

  // Sources that are not appended report slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != DEC_ACCEPT || out_tdata[57]) |-> out_tdata[11:0] == 12'd0)
    else $error("nonzero slot for a source not appended");

endmodule

bind tree_multipole_acceptance_test_top tmac_checker u_tmac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
